FILE: sv/blake2s_hash_engine_assert.svh
// assertion macros for the checker file
`ifndef BLAKE2S_HASH_ENGINE_ASSERT_SVH
`define BLAKE2S_HASH_ENGINE_ASSERT_SVH

// overlapping implication, checked outside reset
`define BHE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blake2s engine check failed");

// next-cycle implication, checked outside reset
`define BHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blake2s engine check failed");

`endif

FILE: sv/bhe_pkg.sv
// ----------------------------------------------------------------------------
// bhe_pkg
// constants and helpers for the blake2s-256 engine
// ----------------------------------------------------------------------------
package bhe_pkg;

    typedef logic [31:0] t_word;

    localparam int BlockBytes = 64;

    // parameter block word for digest length 32, fanout 1, depth 1
    localparam t_word PARAM_WORD = 32'h0101_0020;

    localparam t_word IV [0:7] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    // message schedule, one row per round
    localparam logic [3:0] SIGMA [0:9][0:15] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
        '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
        '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
        '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
        '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
        '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
        '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
        '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
        '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
    };

    function automatic t_word ror32(input t_word v, input logic [4:0] k);
        ror32 = (v >> k) | (v << (6'd32 - {1'b0, k}));
    endfunction

endpackage

FILE: sv/bhe_msg_if.sv
// ----------------------------------------------------------------------------
// bhe_msg_if / bhe_dig_if
// valid/ready channels for message words and digests
// ----------------------------------------------------------------------------
interface bhe_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_flag;

    modport source (output valid, data_word, byte_count, last_flag, input ready);
    modport sink   (input valid, data_word, byte_count, last_flag, output ready);
endinterface

interface bhe_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_w0;
    logic [31:0] digest_w1;
    logic [31:0] digest_w2;
    logic [31:0] digest_w3;
    logic [31:0] digest_w4;
    logic [31:0] digest_w5;
    logic [31:0] digest_w6;
    logic [31:0] digest_w7;
    logic        format_error;

    modport source (output valid, digest_w0, digest_w1, digest_w2, digest_w3,
                    digest_w4, digest_w5, digest_w6, digest_w7, format_error,
                    input ready);
    modport sink   (input valid, digest_w0, digest_w1, digest_w2, digest_w3,
                    digest_w4, digest_w5, digest_w6, digest_w7, format_error,
                    output ready);
endinterface

FILE: sv/blake2s_hash_engine.sv
// ----------------------------------------------------------------------------
// blake2s_hash_engine
// unkeyed blake2s-256 hasher, block buffer in a one-port-read memory
// ----------------------------------------------------------------------------
// channel   dir  payload                                  accepted when
// i_msg     in   data_word, byte_count, last_flag         valid & ready
// o_dig     out  digest_w0..digest_w7, format_error       valid & ready
//
// a well-formed item is written to the buffer in the write state; an item with bytes that
// follows a full block first runs a compression: load, half-mix steps, feed-forward.
// the compression does one half of a mix function per cycle on a fixed
// column of the work vector, so 16 halves per round over 10 rounds set its length.
// the last item then runs the final compression (after one more block if one is pending).
// reset (synchronous, active low) restores the initial chain value.
// a new item is taken only when idle and the digest register is empty.
// ----------------------------------------------------------------------------
module blake2s_hash_engine (
    input  logic i_clk,
    input  logic i_rst_n,
    bhe_msg_if.sink   i_msg,
    bhe_dig_if.source o_dig
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]            r_state;
    bhe_pkg::t_word        r_h [0:7];
    bhe_pkg::t_word        r_v [0:15];
    logic [6:0]            r_fill;
    logic [63:0]           r_total;
    logic [4:0]            r_words;
    logic                  r_final;
    logic [3:0]            r_round;
    logic [3:0]            r_step;
    // held item while a pending block compresses
    bhe_pkg::t_word        r_word;
    logic [2:0]            r_cnt;
    logic                  r_last;
    // block buffer memory
    bhe_pkg::t_word        r_mem [0:15];
    bhe_pkg::t_word        r_mdata;
    logic                  r_mvalid;
    // output register
    logic                  r_out_valid;
    bhe_pkg::t_word        r_dig [0:7];
    logic                  r_ferr;

    logic                  in_acc;
    logic [2:0]            sat_cnt;
    bhe_pkg::t_word        masked_word;
    logic [6:0]            n_fill;
    logic [3:0]            rd_addr;
    logic [3:0]            nx_round;
    logic [3:0]            nx_step;
    logic                  mem_we;
    bhe_pkg::t_word        msg;
    bhe_pkg::t_word        ga, gb, gc, gd;
    bhe_pkg::t_word        n_v [0:15];

    assign in_acc      = i_msg.valid && i_msg.ready;
    assign i_msg.ready = (r_state == S_IDLE) && !r_out_valid;

    assign sat_cnt = (i_msg.byte_count > 3'd4) ? 3'd4 : i_msg.byte_count;

    // keep only the valid low lanes of the held word
    always_comb begin
        case (r_cnt)
            3'd0:    masked_word = '0;
            3'd1:    masked_word = {24'd0, r_word[7:0]};
            3'd2:    masked_word = {16'd0, r_word[15:0]};
            3'd3:    masked_word = {8'd0, r_word[23:0]};
            default: masked_word = r_word;
        endcase
    end

    assign n_fill = r_fill + {4'd0, r_cnt};
    assign mem_we = (r_state == S_WR) && (r_cnt != 3'd0);

    // next schedule position
    always_comb begin
        if (r_step == 4'd15) begin
            nx_round = r_round + 4'd1;
            nx_step  = 4'd0;
        end else begin
            nx_round = r_round;
            nx_step  = r_step + 4'd1;
        end
    end

    // read address: first word while loading, next word while running
    always_comb begin
        if (r_state == S_LOAD) begin
            rd_addr = bhe_pkg::SIGMA[0][0];
        end else if (nx_round < 4'd10) begin
            rd_addr = bhe_pkg::SIGMA[nx_round][nx_step];
        end else begin
            rd_addr = 4'd0;
        end
    end

    // block buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill[5:2]] <= masked_word;
        end
        r_mdata  <= r_mem[rd_addr];
        r_mvalid <= {1'b0, rd_addr} < r_words;
    end

    // padding: words past the filled part read as zero
    assign msg = r_mvalid ? r_mdata : '0;

    // half mix on column zero of the work vector
    always_comb begin
        if (!r_step[0]) begin
            ga = r_v[0] + r_v[4] + msg;
            gd = bhe_pkg::ror32(r_v[12] ^ ga, 5'd16);
            gc = r_v[8] + gd;
            gb = bhe_pkg::ror32(r_v[4] ^ gc, 5'd12);
        end else begin
            ga = r_v[0] + r_v[4] + msg;
            gd = bhe_pkg::ror32(r_v[12] ^ ga, 5'd8);
            gc = r_v[8] + gd;
            gb = bhe_pkg::ror32(r_v[4] ^ gc, 5'd7);
        end
    end

    // write back, then rotate rows to bring the next column into place
    always_comb begin
        logic [1:0] sh;
        logic [1:0] src;
        bhe_pkg::t_word t [0:15];
        for (int i = 0; i < 16; i++) begin
            t[i] = r_v[i];
        end
        t[0]  = ga;
        t[4]  = gb;
        t[8]  = gc;
        t[12] = gd;
        for (int k = 0; k < 4; k++) begin
            if (!r_step[0]) begin
                sh = 2'd0;
            end else if (r_step[2:1] != 2'd3) begin
                sh = 2'd1;
            end else if (!r_step[3]) begin
                sh = 2'(k + 1);
            end else begin
                sh = 2'(5 - k);
            end
            for (int c = 0; c < 4; c++) begin
                src = 2'(c) + sh;
                n_v[4 * k + c] = t[4 * k + int'(src)];
            end
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_final     <= 1'b0;
            r_round     <= '0;
            r_step      <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= bhe_pkg::IV[i] ^ ((i == 0) ? bhe_pkg::PARAM_WORD : '0);
            end
        end else begin
            if (o_dig.valid && o_dig.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_word <= i_msg.data_word;
                        r_cnt  <= sat_cnt;
                        r_last <= i_msg.last_flag;
                        if (!i_msg.last_flag && sat_cnt != 3'd4) begin
                            r_out_valid <= 1'b1;
                            r_ferr      <= 1'b1;
                            for (int i = 0; i < 8; i++) begin
                                r_dig[i] <= '0;
                            end
                        end else if (sat_cnt != 3'd0 && r_fill >= 7'(bhe_pkg::BlockBytes)) begin
                            r_total <= r_total + 64'(bhe_pkg::BlockBytes);
                            r_words <= 5'd16;
                            r_final <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    r_fill <= n_fill;
                    if (r_last) begin
                        r_total <= r_total + {57'd0, n_fill};
                        r_words <= 5'((8'(n_fill) + 8'd3) >> 2);
                        r_final <= 1'b1;
                        r_state <= S_LOAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_v[i] <= r_h[i];
                    end
                    r_v[8]  <= bhe_pkg::IV[0];
                    r_v[9]  <= bhe_pkg::IV[1];
                    r_v[10] <= bhe_pkg::IV[2];
                    r_v[11] <= bhe_pkg::IV[3];
                    r_v[12] <= bhe_pkg::IV[4] ^ r_total[31:0];
                    r_v[13] <= bhe_pkg::IV[5] ^ r_total[63:32];
                    r_v[14] <= r_final ? ~bhe_pkg::IV[6] : bhe_pkg::IV[6];
                    r_v[15] <= bhe_pkg::IV[7];
                    r_round <= '0;
                    r_step  <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    for (int i = 0; i < 16; i++) begin
                        r_v[i] <= n_v[i];
                    end
                    r_round <= nx_round;
                    r_step  <= nx_step;
                    if (r_round == 4'd9 && r_step == 4'd15) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_final) begin
                        r_out_valid <= 1'b1;
                        r_ferr      <= 1'b0;
                        for (int i = 0; i < 8; i++) begin
                            r_dig[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
                            r_h[i]   <= bhe_pkg::IV[i] ^
                                        ((i == 0) ? bhe_pkg::PARAM_WORD : '0);
                        end
                        r_fill  <= '0;
                        r_total <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
                        end
                        r_fill  <= '0;
                        r_state <= S_WR;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result port
    assign o_dig.valid        = r_out_valid;
    assign o_dig.digest_w0    = r_dig[0];
    assign o_dig.digest_w1    = r_dig[1];
    assign o_dig.digest_w2    = r_dig[2];
    assign o_dig.digest_w3    = r_dig[3];
    assign o_dig.digest_w4    = r_dig[4];
    assign o_dig.digest_w5    = r_dig[5];
    assign o_dig.digest_w6    = r_dig[6];
    assign o_dig.digest_w7    = r_dig[7];
    assign o_dig.format_error = r_ferr;

endmodule

FILE: sv/bhe_checker.sv
// ----------------------------------------------------------------------------
// bhe_checker
// port-level checks for the blake2s engine, bound to the top level
// ----------------------------------------------------------------------------
`include "blake2s_hash_engine_assert.svh"

module bhe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  in_count,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ferr,
    input logic [31:0] out_w0,
    input logic [31:0] out_w7
);

    logic in_acc;
    logic short_item;

    assign in_acc     = in_valid && in_ready;
    assign short_item = !in_last && (in_count != 3'd4) && (in_count < 3'd5);

    // a waiting result holds
    `BHE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_w0))

    // one item at a time
    `BHE_ASSERT_NEXT(a_busy_after_item, i_clk, i_rst_n, in_acc, !in_ready)

    // a short non-last item reports an error at once
    `BHE_ASSERT_NEXT(a_short_err, i_clk, i_rst_n, in_acc && short_item, out_valid && out_ferr)

    // an error result carries no digest
    `BHE_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, out_valid && out_ferr, out_w0 == 32'd0 && out_w7 == 32'd0)

endmodule

bind blake2s_hash_engine bhe_checker u_bhe_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_msg.valid),
    .in_ready  (i_msg.ready),
    .in_count  (i_msg.byte_count),
    .in_last   (i_msg.last_flag),
    .out_valid (o_dig.valid),
    .out_ready (o_dig.ready),
    .out_ferr  (o_dig.format_error),
    .out_w0    (o_dig.digest_w0),
    .out_w7    (o_dig.digest_w7)
);

FILE: tb/tb_blake2s_if_note.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blake2s_if_note
// testbench types for the blake2s-256 engine bench
// ----------------------------------------------------------------------------
package tb_bhe_types_pkg;

    // one message word as offered on the input channel
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_flag;
    } t_msg_item;

    // one digest item as seen on the output channel
    typedef struct packed {
        logic [7:0][31:0] digest;
        logic             format_error;
    } t_dig_item;

endpackage

FILE: tb/tb_blake2s_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blake2s_hash_engine
// self-checking bench: message words in, digests out, compared against an
// in-bench blake2s-256 predictor under random idling on both channels
// ----------------------------------------------------------------------------
module tb_blake2s_hash_engine;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;
    bhe_msg_if msg_ch ();
    bhe_dig_if dig_ch ();

    blake2s_hash_engine DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_msg  (msg_ch.sink),
        .o_dig  (dig_ch.source)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // predictor state
    bhe_pkg::t_word hash_state [0:7];
    bhe_pkg::t_word block_words [0:15];
    int             bytes_held;
    bit [63:0]      bytes_done;

    tb_bhe_types_pkg::t_dig_item digest_queue [$];
    int        fail_count;
    bit        stim_done;
    bit        hold_off;
    int        quiet_cycles = 0;
    int        stall_left = 0;

    function automatic bhe_pkg::t_word rotr(input bhe_pkg::t_word v, input int k);
        rotr = (v >> k) | (v << (32 - k));
    endfunction

    // append one expected digest item
    function automatic void expect_digest(input tb_bhe_types_pkg::t_dig_item d);
        digest_queue = {digest_queue, d};
    endfunction

    task automatic hash_init();
        for (int i = 0; i < 8; i++) hash_state[i] = bhe_pkg::IV[i];
        hash_state[0] ^= bhe_pkg::PARAM_WORD;
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        bytes_held = 0;
        bytes_done = '0;
    endtask

    task automatic g_mix(inout bhe_pkg::t_word w [0:15], input int a, input int b,
                         input int c, input int d, input bhe_pkg::t_word x,
                         input bhe_pkg::t_word y);
        w[a] = w[a] + w[b] + x;
        w[d] = rotr(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d];
        w[b] = rotr(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b] + y;
        w[d] = rotr(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d];
        w[b] = rotr(w[b] ^ w[c], 7);
    endtask

    task automatic compress(input bhe_pkg::t_word m [0:15], input bit is_final);
        bhe_pkg::t_word w [0:15];
        for (int i = 0; i < 8; i++) begin
            w[i] = hash_state[i];
            w[i + 8] = bhe_pkg::IV[i];
        end
        w[12] ^= bytes_done[31:0];
        w[13] ^= bytes_done[63:32];
        if (is_final) w[14] = ~w[14];
        for (int r = 0; r < 10; r++) begin
            g_mix(w, 0, 4, 8, 12, m[bhe_pkg::SIGMA[r][0]], m[bhe_pkg::SIGMA[r][1]]);
            g_mix(w, 1, 5, 9, 13, m[bhe_pkg::SIGMA[r][2]], m[bhe_pkg::SIGMA[r][3]]);
            g_mix(w, 2, 6, 10, 14, m[bhe_pkg::SIGMA[r][4]], m[bhe_pkg::SIGMA[r][5]]);
            g_mix(w, 3, 7, 11, 15, m[bhe_pkg::SIGMA[r][6]], m[bhe_pkg::SIGMA[r][7]]);
            g_mix(w, 0, 5, 10, 15, m[bhe_pkg::SIGMA[r][8]], m[bhe_pkg::SIGMA[r][9]]);
            g_mix(w, 1, 6, 11, 12, m[bhe_pkg::SIGMA[r][10]], m[bhe_pkg::SIGMA[r][11]]);
            g_mix(w, 2, 7, 8, 13, m[bhe_pkg::SIGMA[r][12]], m[bhe_pkg::SIGMA[r][13]]);
            g_mix(w, 3, 4, 9, 14, m[bhe_pkg::SIGMA[r][14]], m[bhe_pkg::SIGMA[r][15]]);
        end
        for (int i = 0; i < 8; i++) hash_state[i] ^= w[i] ^ w[i + 8];
    endtask

    // absorb one accepted item, queue the digest it causes
    task automatic absorb_word(input tb_bhe_types_pkg::t_msg_item it);
        tb_bhe_types_pkg::t_dig_item d;
        bhe_pkg::t_word padded [0:15];
        int             n;
        int             used;
        bhe_pkg::t_word wd;
        n = (it.byte_count > 4) ? 4 : int'(it.byte_count);
        wd = it.data_word;
        if (!it.last_flag && n < 4) begin
            d = '0;
            d.format_error = 1'b1;
            expect_digest(d);
            return;
        end
        // full buffer goes out only once more bytes show up
        if (n > 0 && bytes_held >= 64) begin
            bytes_done += 64;
            compress(block_words, 1'b0);
            bytes_held = 0;
        end
        if (n > 0) begin
            if (n < 4) wd &= (32'h1 << (8 * n)) - 1;
            block_words[(bytes_held >> 2) & 15] = wd;
            bytes_held += n;
        end
        if (!it.last_flag) return;
        used = (bytes_held + 3) >> 2;
        for (int i = 0; i < 16; i++) padded[i] = (i < used) ? block_words[i] : '0;
        bytes_done += bytes_held;
        compress(padded, 1'b1);
        d = '0;
        for (int i = 0; i < 8; i++) d.digest[i] = hash_state[i];
        expect_digest(d);
        hash_init();
    endtask

    // directed rows; check marks rows whose digest is typed in
    typedef struct {
        tb_bhe_types_pkg::t_msg_item item;
        bit                          check;
        tb_bhe_types_pkg::t_dig_item want;
    } t_vector;

    t_vector                     vectors [$];
    tb_bhe_types_pkg::t_msg_item rand_items [$];

    function automatic tb_bhe_types_pkg::t_dig_item fixed_digest(input logic [255:0] w,
                                                                input bit err);
        tb_bhe_types_pkg::t_dig_item d;
        for (int i = 0; i < 8; i++) d.digest[i] = w[32 * i +: 32];
        d.format_error = err;
        return d;
    endfunction

    function automatic t_vector row(input logic [31:0] w, input int n, input bit l);
        t_vector v;
        v.item = '{w, 3'(n), l};
        v.check = 1'b0;
        v.want = '0;
        return v;
    endfunction

    task automatic build_directed();
        t_vector v;
        // empty message, published digest of the empty string
        v = row(32'h0, 0, 1);
        v.check = 1'b1;
        v.want = fixed_digest({32'hF9EED01E, 32'hFD0D251B, 32'h1EA5A12C, 32'h48B6551F,
                               32'h7C4A3542, 32'hD02111E1, 32'h94809079, 32'h307A2169}, 0);
        vectors = {vectors, v};
        // "abc", published digest
        v = row(32'h00636261, 3, 1);
        v.check = 1'b1;
        v.want = fixed_digest({32'h82596786, 32'h4C9B994D, 32'h293AD69E, 32'h208B4537,
                               32'h2F45EB4E, 32'hA32BA7E1, 32'hE2147C32, 32'h8C5E8C50}, 0);
        vectors = {vectors, v};
        // short non-last words are dropped with an error
        for (int n = 0; n < 4; n++) begin
            v = row(32'hFFFFFFFF, n, 0);
            v.check = 1'b1;
            v.want = fixed_digest('0, 1);
            vectors = {vectors, v};
        end
        // exactly one full block, final block stays in buffer
        for (int i = 0; i < 15; i++) begin
            v = row(i[0] ? 32'hFFFFFFFF : 32'h0, 4, 0);
            vectors = {vectors, v};
        end
        v = row(32'hFFFFFFFF, 4, 1);
        vectors = {vectors, v};
        // saturated count, then last word with zero bytes after a full word
        v = row(32'h89ABCDEF, 7, 0);
        vectors = {vectors, v};
        v = row(32'h01234567, 5, 1);
        vectors = {vectors, v};
        v = row(32'hDEADBEEF, 4, 0);
        vectors = {vectors, v};
        v = row(32'hFFFFFFFF, 0, 1);
        vectors = {vectors, v};
    endtask

    // random messages: mostly well-formed, some noise words
    task automatic build_random();
        int total;
        int len;
        tb_bhe_types_pkg::t_msg_item mi;
        total = 0;
        while (total < 1850) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 50)
                                               : $urandom_range(0, 20);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 30) == 0)
                    mi = '{$urandom, 3'($urandom_range(0, 3)), 1'b0};
                else
                    mi = '{$urandom, 3'($urandom_range(4, 7)), 1'b0};
                rand_items = {rand_items, mi};
            end
            mi = '{$urandom, 3'($urandom_range(0, 7)), 1'b1};
            rand_items = {rand_items, mi};
            total += len + 1;
        end
    endtask

    // sender: valid drops only while idling between items
    task automatic send_word(input tb_bhe_types_pkg::t_msg_item it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_word  <= it.data_word;
        msg_ch.byte_count <= it.byte_count;
        msg_ch.last_flag  <= it.last_flag;
        do @(posedge i_clk); while (!msg_ch.ready);
        absorb_word(it);
    endtask

    initial begin
        msg_ch.valid = 1'b0;
        msg_ch.data_word = '0;
        msg_ch.byte_count = '0;
        msg_ch.last_flag = 1'b0;
        i_rst_n = 1'b0;
        fail_count = 0;
        stim_done = 1'b0;
        hash_init();
        build_directed();
        build_random();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (vectors[k]) begin
            send_word(vectors[k].item);
            // typed-in rows: the predictor must agree with the known value
            if (vectors[k].check && digest_queue[$] != vectors[k].want) begin
                $error("predicted digest differs from known value, row %0d", k);
                fail_count++;
                digest_queue[$] = vectors[k].want;
            end
        end
        foreach (rand_items[k]) send_word(rand_items[k]);
        msg_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls and one long hold-off
    initial begin
        dig_ch.ready = 1'b0;
        hold_off = 1'b0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            dig_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else if (dig_ch.valid && dig_ch.ready) begin
            stall_left <= $urandom_range(0, 3);
            dig_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            dig_ch.ready <= 1'b0;
        end else begin
            dig_ch.ready <= 1'b1;
        end
    end

    // digest checker
    always @(posedge i_clk) begin
        tb_bhe_types_pkg::t_dig_item exp_d;
        tb_bhe_types_pkg::t_dig_item got;
        if (i_rst_n && dig_ch.valid && dig_ch.ready) begin
            got.digest[0] = dig_ch.digest_w0;
            got.digest[1] = dig_ch.digest_w1;
            got.digest[2] = dig_ch.digest_w2;
            got.digest[3] = dig_ch.digest_w3;
            got.digest[4] = dig_ch.digest_w4;
            got.digest[5] = dig_ch.digest_w5;
            got.digest[6] = dig_ch.digest_w6;
            got.digest[7] = dig_ch.digest_w7;
            got.format_error = dig_ch.format_error;
            if (digest_queue.size() == 0) begin
                $error("digest item with nothing expected");
                fail_count++;
            end else begin
                exp_d = digest_queue.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got.digest[i] !== exp_d.digest[i]) begin
                        $error("digest_w%0d expected %h got %h", i,
                               exp_d.digest[i], got.digest[i]);
                        fail_count++;
                    end
                if (got.format_error !== exp_d.format_error) begin
                    $error("format_error expected %b got %b",
                           exp_d.format_error, got.format_error);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready)
            || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        fork
            begin
                wait (stim_done);
                while (digest_queue.size() != 0) @(posedge i_clk);
                repeat (SETTLE_CYCLES) @(posedge i_clk);
            end
            begin
                wait (quiet_cycles >= IDLE_LIMIT);
                $error("no progress for %0d cycles", IDLE_LIMIT);
                fail_count++;
            end
        join_any
        if (digest_queue.size() != 0) begin
            $error("%0d digest items never arrived", digest_queue.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("PASS blake2s_hash_engine");
        else
            $display("FAIL blake2s_hash_engine");
        $finish;
    end

endmodule
